/* rtl/fbm_pkg.sv */
package fbm_pkg;

	localparam int OCTAVE_COUNT_DEF = 4;
	localparam int ANGLE_BITS_DEF   = 10;
	localparam int COORD_BITS_DEF   = 16;

	// running octave sum (Q6.14) and corner dot (Q4.14) widths, signed
	localparam int SUM_W    = 20;
	localparam int CORNER_W = 18;

	localparam logic [31:0] HASH_K1 = 32'h9E37_79B9;
	localparam logic [31:0] HASH_K2 = 32'h85EB_CA77;

	localparam logic [15:0] FREQ_RESET = 16'd655;

	// odd taylor terms of sin(pi/2 * u), Q30
	localparam logic [30:0] SIN_C0 = 31'd1686629713;
	localparam logic [30:0] SIN_C1 = 31'd693598668;
	localparam logic [30:0] SIN_C2 = 31'd85569305;
	localparam logic [30:0] SIN_C3 = 31'd5026997;
	localparam logic [30:0] SIN_C4 = 31'd172272;
	localparam logic [30:0] Q30_ONE = 31'h4000_0000;

	// band edges: 5t <= k * 32768  <=>  t <= floor(k * 32768 / 5)
	localparam int BAND_1 = (1 * 32768) / 5;
	localparam int BAND_2 = (2 * 32768) / 5;
	localparam int BAND_3 = (3 * 32768) / 5;
	localparam int BAND_4 = (4 * 32768) / 5;
	localparam int HALF_RANGE = 16384;

	localparam logic REG_SEED = 1'b0;
	localparam logic REG_FREQ = 1'b1;

	typedef struct packed {
		logic               valid;
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [SUM_W-1:0] sum;
	} beat_t;

	typedef struct packed {
		logic [31:0] seed;
		logic [31:0] seed_mul;
		logic [15:0] freq;
	} cfg_t;

	function automatic logic [31:0] rotl16(input logic [31:0] v);
		return {v[15:0], v[31:16]};
	endfunction

	function automatic logic [30:0] mulq30(input logic [30:0] a, input logic [30:0] b);
		logic [61:0] p;
		p = 62'(a) * 62'(b);
		return p[60:30];
	endfunction

	function automatic logic [2:0] band_of(input logic signed [SUM_W-1:0] sum);
		logic signed [SUM_W:0] t;
		t = (SUM_W+1)'(sum) + (SUM_W+1)'(HALF_RANGE);
		// below the clip floor t is negative and lands in band 0, above the ceiling in band 4
		if (t <= (SUM_W+1)'(BAND_1))
			return 3'd0;
		else if (t <= (SUM_W+1)'(BAND_2))
			return 3'd1;
		else if (t <= (SUM_W+1)'(BAND_3))
			return 3'd2;
		else if (t <= (SUM_W+1)'(BAND_4))
			return 3'd3;
		else
			return 3'd4;
	endfunction

endpackage

/* rtl/fbm_perlin_noise_pixel_core.sv */
// Fractal gradient noise, one grey pixel per input coordinate.
// Input channel: in_valid/in_ready with pixel_x, pixel_y (signed). Output channel:
// out_valid/out_ready with grey_level (band 0..4) and grey_value (band * 51).
// Configuration: wr_en writes wr_data into the register picked by wr_index
// (0 seed, 1 base frequency) at the clock edge; write only while no pixel is in flight.
// Throughput: one pixel per cycle while the output buffer is not full. The datapath
// is a chain of one cell per octave, each a 14-stage pipeline, then one banding
// stage and a two-entry output buffer. The corner hash and sine polynomial set the
// cell depth.
// When the receiver stalls, results collect in the output buffer; the whole
// pipeline holds and in_ready drops only once both entries are full, so pixels
// keep being taken while one result waits.
// Reset (arst_n low) empties the pipeline and the buffer, sets the seed to 0 and
// the base frequency to 655.
module fbm_perlin_noise_pixel_core import fbm_pkg::*; #(
	parameter int OCTAVE_COUNT = OCTAVE_COUNT_DEF,
	parameter int ANGLE_BITS   = ANGLE_BITS_DEF,
	parameter int COORD_BITS   = COORD_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] pixel_x,
	input  logic signed [15:0] pixel_y,
	input  logic               wr_en,
	input  logic               wr_index,
	input  logic [31:0]        wr_data,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [7:0]         grey_value,
	output logic [2:0]         grey_level
);

	logic [31:0] seed_q, seed_mul_q;
	logic [15:0] freq_q;
	cfg_t        cfg;
	logic        en;
	beat_t       link [OCTAVE_COUNT+1];
	logic        lvl_vld_s1;
	logic [2:0]  lvl_s1;
	logic [2:0]  buf_q [2];
	logic        wr_ptr_q, rd_ptr_q;
	logic [1:0]  cnt_q;
	logic        push, pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0;
			freq_q <= FREQ_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_SEED: seed_q <= wr_data;
				REG_FREQ: freq_q <= wr_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		seed_mul_q <= seed_q * HASH_K2;
	end

	assign cfg = '{seed: seed_q, seed_mul: seed_mul_q, freq: freq_q};

	assign en       = (cnt_q != 2'd2);
	assign in_ready = en;

	assign link[0] = '{valid: in_valid && in_ready, x: pixel_x, y: pixel_y, sum: '0};

	for (genvar k = 0; k < OCTAVE_COUNT; k++) begin : g_oct
		fbm_cell #(
			.OCT(k), .ANGLE_BITS(ANGLE_BITS), .COORD_BITS(COORD_BITS)
		) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en), .cfg(cfg),
			.in_beat(link[k]), .out_beat(link[k+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lvl_vld_s1 <= 1'b0;
			lvl_s1     <= '0;
		end else if (en) begin
			lvl_vld_s1 <= link[OCTAVE_COUNT].valid;
			lvl_s1     <= band_of(link[OCTAVE_COUNT].sum);
		end
	end

	assign push = en && lvl_vld_s1;
	assign pop  = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= '0;
			buf_q[0] <= '0;
			buf_q[1] <= '0;
		end else begin
			if (push) begin
				buf_q[wr_ptr_q] <= lvl_s1;
				wr_ptr_q        <= ~wr_ptr_q;
			end
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	assign out_valid  = (cnt_q != 2'd0);
	assign grey_level = buf_q[rd_ptr_q];
	assign grey_value = 8'(grey_level) * 8'd51;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("output buffer count out of range");

	a_fall_on_pop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_valid) |-> $past(out_ready))
		else $error("result dropped without a pop");

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (grey_level <= 3'd4))
		else $error("grey level out of range");

endmodule

/* rtl/fbm_qsin.sv */
module fbm_qsin import fbm_pkg::*; (
	input  logic        clk,
	input  logic        en,
	input  logic [30:0] u,
	output logic [15:0] s
);

	logic [30:0] u_s1, u_s2, u_s3, u_s4, u_s5;
	logic [30:0] u2_s1, u2_s2, u2_s3, u2_s4;
	logic [30:0] p3_s2, p2_s3, p1_s4, p0_s5;
	logic [30:0] sv;
	logic [15:0] s_s6;

	assign sv = mulq30(u_s5, p0_s5);

	// horner steps, one multiply per stage
	always_ff @(posedge clk) begin
		if (en) begin
			u_s1  <= u;
			u2_s1 <= mulq30(u, u);
			u_s2  <= u_s1;
			u2_s2 <= u2_s1;
			p3_s2 <= SIN_C3 - mulq30(u2_s1, SIN_C4);
			u_s3  <= u_s2;
			u2_s3 <= u2_s2;
			p2_s3 <= SIN_C2 - mulq30(u2_s2, p3_s2);
			u_s4  <= u_s3;
			u2_s4 <= u2_s3;
			p1_s4 <= SIN_C1 - mulq30(u2_s3, p2_s3);
			u_s5  <= u_s4;
			p0_s5 <= SIN_C0 - mulq30(u2_s4, p1_s4);
			s_s6  <= 16'((32'(sv) + 32'd32768) >> 16);
		end
	end

	assign s = s_s6;

endmodule

/* rtl/fbm_corner.sv */
module fbm_corner import fbm_pkg::*; #(
	parameter int   ANGLE_BITS = ANGLE_BITS_DEF,
	parameter logic SHIFT_X    = 1'b0,
	parameter logic SHIFT_Y    = 1'b0
) (
	input  logic                       clk,
	input  logic                       en,
	input  cfg_t                       cfg,
	input  logic [31:0]                cx,
	input  logic [31:0]                cy,
	input  logic [15:0]                fx,
	input  logic [15:0]                fy,
	output logic signed [CORNER_W-1:0] dot
);

	typedef enum logic [1:0] {QUAD_I, QUAD_II, QUAD_III, QUAD_IV} quad_t;

	localparam int QSIN_LAT = 6;

	logic [31:0] a_s1, cy_s1, a_s2, b_s2, a_s3;
	logic [ANGLE_BITS-1:0] ph;
	logic [29:0] t30;
	logic [30:0] u_sin, u_cos;
	logic [15:0] sn, cs;
	quad_t       quad_q [QSIN_LAT];
	logic signed [16:0] gx, gy, dx, dy;
	logic signed [34:0] acc;
	logic signed [CORNER_W-1:0] dot_q;

	// gradient hash
	always_ff @(posedge clk) begin
		if (en) begin
			a_s1  <= cx * cfg.seed;
			cy_s1 <= cy;
			b_s2  <= (cy_s1 ^ rotl16(a_s1)) * (cfg.seed ^ HASH_K1);
			a_s2  <= a_s1;
			a_s3  <= (a_s2 ^ rotl16(b_s2)) * cfg.seed_mul;
		end
	end

	assign ph    = a_s3[31 -: ANGLE_BITS];
	assign t30   = {ph[ANGLE_BITS-3:0], {(32-ANGLE_BITS){1'b0}}};
	assign u_sin = {1'b0, t30};
	assign u_cos = Q30_ONE - u_sin;

	fbm_qsin u_qsin_s (.clk(clk), .en(en), .u(u_sin), .s(sn));
	fbm_qsin u_qsin_c (.clk(clk), .en(en), .u(u_cos), .s(cs));

	always_ff @(posedge clk) begin
		if (en) begin
			quad_q[0] <= quad_t'(ph[ANGLE_BITS-1 -: 2]);
			for (int i = 1; i < QSIN_LAT; i++)
				quad_q[i] <= quad_q[i-1];
		end
	end

	always_comb begin
		unique case (quad_q[QSIN_LAT-1])
			QUAD_I: begin
				gx = $signed({1'b0, sn});
				gy = $signed({1'b0, cs});
			end
			QUAD_II: begin
				gx = $signed({1'b0, cs});
				gy = -$signed({1'b0, sn});
			end
			QUAD_III: begin
				gx = -$signed({1'b0, sn});
				gy = -$signed({1'b0, cs});
			end
			default: begin
				gx = -$signed({1'b0, cs});
				gy = $signed({1'b0, sn});
			end
		endcase
	end

	// offset from the far corner is fraction - 1, which is the fraction with a sign bit
	assign dx  = $signed({SHIFT_X, fx});
	assign dy  = $signed({SHIFT_Y, fy});
	assign acc = 35'(dx * gx) + 35'(dy * gy);

	always_ff @(posedge clk) begin
		if (en)
			dot_q <= CORNER_W'(acc >>> 16);
	end

	assign dot = dot_q;

endmodule

/* rtl/fbm_cell.sv */
module fbm_cell import fbm_pkg::*; #(
	parameter int OCT        = 0,
	parameter int ANGLE_BITS = ANGLE_BITS_DEF,
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  cfg_t  cfg,
	input  beat_t in_beat,
	output beat_t out_beat
);

	localparam int FW    = 16 + OCT;
	localparam int PW_A  = 33 + OCT;
	localparam int PW    = (PW_A > 16 + COORD_BITS) ? PW_A : 16 + COORD_BITS;
	localparam int DEPTH = 13;
	localparam int FR_D  = 9;
	localparam int FD_D  = 7;

	logic [FW-1:0] freq;
	logic signed [PW-1:0] xe, ye, fe;
	logic signed [PW-1:0] posx_s1, posy_s1;
	logic signed [COORD_BITS-1:0] cxs, cys, cxp, cyp;
	logic [31:0] x0, x1, y0, y1;
	logic [15:0] w_in [2];
	logic signed [20:0] lin [2];
	logic signed [37:0] ia [2];
	logic [15:0] w_s2 [2];
	logic [15:0] w2_s2 [2];
	logic signed [37:0] ia_s2 [2];
	logic [15:0] w3_s3 [2];
	logic signed [21:0] inner_s3 [2];
	logic signed [17:0] fade_s4 [2];
	logic signed [17:0] fade_q [FD_D][2];
	logic [31:0] frac_q [FR_D];
	logic signed [CORNER_W-1:0] c00, c10, c01, c11;
	logic signed [CORNER_W:0] dtop, dbot;
	logic signed [CORNER_W+18:0] ptop, pbot;
	logic signed [SUM_W-1:0] top_s12, bot_s12, noise_s13;
	logic signed [17:0] sy_s12;
	logic signed [SUM_W:0] dn;
	logic signed [SUM_W+18:0] pn;
	beat_t beat_q [DEPTH];
	beat_t out_s14;

	assign freq = FW'(cfg.freq) << OCT;
	assign xe   = PW'(in_beat.x);
	assign ye   = PW'(in_beat.y);
	assign fe   = PW'({1'b0, freq});

	always_ff @(posedge clk) begin
		if (en) begin
			posx_s1 <= xe * fe;
			posy_s1 <= ye * fe;
		end
	end

	// lattice cells wrap within the coordinate width
	assign cxs = posx_s1[16 +: COORD_BITS];
	assign cys = posy_s1[16 +: COORD_BITS];
	assign cxp = cxs + COORD_BITS'(1);
	assign cyp = cys + COORD_BITS'(1);
	assign x0  = 32'(cxs);
	assign x1  = 32'(cxp);
	assign y0  = 32'(cys);
	assign y1  = 32'(cyp);

	assign w_in[0] = posx_s1[15:0];
	assign w_in[1] = posy_s1[15:0];

	// quintic fade 6w^5 - 15w^4 + 10w^3
	always_comb begin
		for (int d = 0; d < 2; d++) begin
			lin[d] = $signed(21'(w_in[d]) * 21'd6) - 21'sd983040;
			ia[d]  = 38'(lin[d]) * 38'($signed({1'b0, w_in[d]}));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int d = 0; d < 2; d++) begin
				w_s2[d]     <= w_in[d];
				w2_s2[d]    <= 16'((32'(w_in[d]) * 32'(w_in[d])) >> 16);
				ia_s2[d]    <= ia[d];
				w3_s3[d]    <= 16'((32'(w2_s2[d]) * 32'(w_s2[d])) >> 16);
				inner_s3[d] <= 22'(ia_s2[d] >>> 16) + 22'sd655360;
				fade_s4[d]  <= 18'((39'(inner_s3[d]) * 39'($signed({1'b0, w3_s3[d]}))) >>> 16);
				fade_q[0][d] <= fade_s4[d];
				for (int i = 1; i < FD_D; i++)
					fade_q[i][d] <= fade_q[i-1][d];
			end
			frac_q[0] <= {w_in[0], w_in[1]};
			for (int i = 1; i < FR_D; i++)
				frac_q[i] <= frac_q[i-1];
		end
	end

	fbm_corner #(.ANGLE_BITS(ANGLE_BITS), .SHIFT_X(1'b0), .SHIFT_Y(1'b0)) u_c00 (
		.clk(clk), .en(en), .cfg(cfg), .cx(x0), .cy(y0),
		.fx(frac_q[FR_D-1][31:16]), .fy(frac_q[FR_D-1][15:0]), .dot(c00)
	);
	fbm_corner #(.ANGLE_BITS(ANGLE_BITS), .SHIFT_X(1'b1), .SHIFT_Y(1'b0)) u_c10 (
		.clk(clk), .en(en), .cfg(cfg), .cx(x1), .cy(y0),
		.fx(frac_q[FR_D-1][31:16]), .fy(frac_q[FR_D-1][15:0]), .dot(c10)
	);
	fbm_corner #(.ANGLE_BITS(ANGLE_BITS), .SHIFT_X(1'b0), .SHIFT_Y(1'b1)) u_c01 (
		.clk(clk), .en(en), .cfg(cfg), .cx(x0), .cy(y1),
		.fx(frac_q[FR_D-1][31:16]), .fy(frac_q[FR_D-1][15:0]), .dot(c01)
	);
	fbm_corner #(.ANGLE_BITS(ANGLE_BITS), .SHIFT_X(1'b1), .SHIFT_Y(1'b1)) u_c11 (
		.clk(clk), .en(en), .cfg(cfg), .cx(x1), .cy(y1),
		.fx(frac_q[FR_D-1][31:16]), .fy(frac_q[FR_D-1][15:0]), .dot(c11)
	);

	assign dtop = (CORNER_W+1)'(c10) - (CORNER_W+1)'(c00);
	assign dbot = (CORNER_W+1)'(c11) - (CORNER_W+1)'(c01);
	assign ptop = (CORNER_W+19)'(dtop) * (CORNER_W+19)'(fade_q[FD_D-1][0]);
	assign pbot = (CORNER_W+19)'(dbot) * (CORNER_W+19)'(fade_q[FD_D-1][0]);
	assign dn   = (SUM_W+1)'(bot_s12) - (SUM_W+1)'(top_s12);
	assign pn   = (SUM_W+19)'(dn) * (SUM_W+19)'(sy_s12);

	always_ff @(posedge clk) begin
		if (en) begin
			top_s12   <= SUM_W'(c00) + SUM_W'(ptop >>> 16);
			bot_s12   <= SUM_W'(c01) + SUM_W'(pbot >>> 16);
			sy_s12    <= fade_q[FD_D-1][1];
			noise_s13 <= top_s12 + SUM_W'(pn >>> 16);
		end
	end

	// pixel and running sum ride along with the octave pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++)
				beat_q[i] <= '0;
			out_s14 <= '0;
		end else if (en) begin
			beat_q[0] <= in_beat;
			for (int i = 1; i < DEPTH; i++)
				beat_q[i] <= beat_q[i-1];
			out_s14.valid <= beat_q[DEPTH-1].valid;
			out_s14.x     <= beat_q[DEPTH-1].x;
			out_s14.y     <= beat_q[DEPTH-1].y;
			out_s14.sum   <= beat_q[DEPTH-1].sum + (noise_s13 >>> OCT);
		end
	end

	assign out_beat = out_s14;

endmodule
